// ===== rtl/core/i2cs_pkg.sv =====
// ----------------------------------------------------------------------------
// i2cs_pkg
// Shared types and constants for the I2C write-then-read sequencer.
// ----------------------------------------------------------------------------
package i2cs_pkg;

  // Default write buffer depth
  localparam int BUFFER_DEPTH = 16;

  // Highest number of bytes a single transaction reads
  localparam logic [4:0] READ_LIMIT = 5'd16;

  // Field widths
  localparam int MODE_W  = 2;
  localparam int ADDR_W  = 7;
  localparam int COUNT_W = 5;
  localparam int LIDX_W  = 4;
  localparam int BYTE_W  = 8;
  localparam int CMD_W   = 3;
  localparam int RIDX_W  = 4;
  localparam int STAT_W  = 2;

  // Request kinds
  typedef enum logic [MODE_W-1:0] {
    MODE_LOAD  = 2'd0,
    MODE_BEGIN = 2'd1,
    MODE_DONE  = 2'd2
  } mode_e;

  // Commands to the bus engine
  typedef enum logic [CMD_W-1:0] {
    CMD_NONE    = 3'd0,
    CMD_START   = 3'd1,
    CMD_TX      = 3'd2,
    CMD_RESTART = 3'd3,
    CMD_STOP    = 3'd4,
    CMD_RX      = 3'd5,
    CMD_ACK     = 3'd6,
    CMD_NACK    = 3'd7
  } cmd_e;

  // Reported status
  typedef enum logic [STAT_W-1:0] {
    STATUS_IDLE  = 2'd0,
    STATUS_BUSY  = 2'd1,
    STATUS_ERROR = 2'd2
  } status_e;

  // Transaction phase
  typedef enum logic [3:0] {
    PH_IDLE    = 4'd0,
    PH_START   = 4'd1,
    PH_WRITE   = 4'd2,
    PH_READ    = 4'd3,
    PH_RESTART = 4'd4,
    PH_ACK     = 4'd5,
    PH_NACK    = 4'd6,
    PH_STOP    = 4'd7,
    PH_ERROR   = 4'd8
  } phase_e;

  // One request item
  typedef struct packed {
    logic [MODE_W-1:0]  mode;
    logic [ADDR_W-1:0]  slave_address;
    logic [COUNT_W-1:0] write_count;
    logic [COUNT_W-1:0] read_count;
    logic [LIDX_W-1:0]  load_index;
    logic [BYTE_W-1:0]  load_byte;
    logic               ack_missing;
    logic [BYTE_W-1:0]  received_byte;
  } item_t;

  // One result item
  typedef struct packed {
    cmd_e              bus_command;
    logic [BYTE_W-1:0] tx_byte;
    logic              rx_valid;
    logic [BYTE_W-1:0] rx_byte;
    logic [RIDX_W-1:0] rx_index;
    status_e           status;
  } rsp_t;

  // Write buffer store request
  typedef struct packed {
    logic              en;
    logic [LIDX_W-1:0] idx;
    logic [BYTE_W-1:0] data;
  } wbuf_wr_t;

endpackage

// ===== rtl/core/i2cs_if.sv =====
// ----------------------------------------------------------------------------
// i2cs_if
// Valid/ready channels for requests and results of the I2C sequencer.
// ----------------------------------------------------------------------------
interface i2cs_req_if;
  logic                           valid;
  logic                           ready;
  logic [i2cs_pkg::MODE_W-1:0]    mode;
  logic [i2cs_pkg::ADDR_W-1:0]    slave_address;
  logic [i2cs_pkg::COUNT_W-1:0]   write_count;
  logic [i2cs_pkg::COUNT_W-1:0]   read_count;
  logic [i2cs_pkg::LIDX_W-1:0]    load_index;
  logic [i2cs_pkg::BYTE_W-1:0]    load_byte;
  logic                           ack_missing;
  logic [i2cs_pkg::BYTE_W-1:0]    received_byte;

  modport source (
    output valid, mode, slave_address, write_count, read_count,
           load_index, load_byte, ack_missing, received_byte,
    input  ready
  );
  modport sink (
    input  valid, mode, slave_address, write_count, read_count,
           load_index, load_byte, ack_missing, received_byte,
    output ready
  );
endinterface

interface i2cs_rsp_if;
  logic                          valid;
  logic                          ready;
  logic [i2cs_pkg::CMD_W-1:0]    bus_command;
  logic [i2cs_pkg::BYTE_W-1:0]   tx_byte;
  logic                          rx_valid;
  logic [i2cs_pkg::BYTE_W-1:0]   rx_byte;
  logic [i2cs_pkg::RIDX_W-1:0]   rx_index;
  logic [i2cs_pkg::STAT_W-1:0]   status;

  modport source (
    output valid, bus_command, tx_byte, rx_valid, rx_byte, rx_index, status,
    input  ready
  );
  modport sink (
    input  valid, bus_command, tx_byte, rx_valid, rx_byte, rx_index, status,
    output ready
  );
endinterface

// ===== rtl/core/i2cs_wbuf.sv =====
// ----------------------------------------------------------------------------
// i2cs_wbuf
// Write data buffer: register file with one store port and one read port.
// ----------------------------------------------------------------------------
module i2cs_wbuf #(
  parameter int BufferDepth = i2cs_pkg::BUFFER_DEPTH
) (
  input  logic                          clk_i,
  input  i2cs_pkg::wbuf_wr_t            wr_i,
  input  logic [i2cs_pkg::COUNT_W-1:0]  rd_addr_i,
  output logic [i2cs_pkg::BYTE_W-1:0]   rd_data_o
);

  // Only indexes reachable by the load index are ever stored
  localparam int LoadSpan   = 1 << i2cs_pkg::LIDX_W;
  localparam int StoreDepth = (BufferDepth < LoadSpan) ? BufferDepth : LoadSpan;
  localparam int IdxW       = (StoreDepth > 1) ? $clog2(StoreDepth) : 1;

  logic [i2cs_pkg::BYTE_W-1:0] mem_q [StoreDepth];
  logic                        wr_ok;

  // Drop loads beyond the buffer depth
  assign wr_ok = wr_i.en && (int'(wr_i.idx) < BufferDepth);

  // Store the loaded byte
  always_ff @(posedge clk_i) begin
    if (wr_ok) begin
      mem_q[wr_i.idx[IdxW-1:0]] <= wr_i.data;
    end
  end

  // Read the byte at the current write position
  assign rd_data_o = mem_q[rd_addr_i[IdxW-1:0]];

endmodule

// ===== rtl/core/i2cs_fsm.sv =====
// ----------------------------------------------------------------------------
// i2cs_fsm
// Transaction state machine: takes one request per step and forms its result.
// ----------------------------------------------------------------------------
module i2cs_fsm #(
  parameter int BufferDepth = i2cs_pkg::BUFFER_DEPTH
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          step_i,
  input  i2cs_pkg::item_t               item_i,
  input  logic [i2cs_pkg::BYTE_W-1:0]   rd_data_i,
  output logic [i2cs_pkg::COUNT_W-1:0]  rd_addr_o,
  output i2cs_pkg::wbuf_wr_t            wr_o,
  output i2cs_pkg::rsp_t                rsp_o
);

  // Largest write count the buffer allows
  localparam int CountMax = (1 << i2cs_pkg::COUNT_W) - 1;
  localparam logic [i2cs_pkg::COUNT_W-1:0] WriteCap =
    i2cs_pkg::COUNT_W'((BufferDepth > CountMax) ? CountMax : BufferDepth);

  i2cs_pkg::phase_e               phase_q, phase_d;
  logic [i2cs_pkg::COUNT_W-1:0]   wpos_q, wpos_d;
  logic [i2cs_pkg::COUNT_W-1:0]   rpos_q, rpos_d;
  logic [i2cs_pkg::ADDR_W-1:0]    addr_q, addr_d;
  logic [i2cs_pkg::COUNT_W-1:0]   btw_q, btw_d;
  logic [i2cs_pkg::COUNT_W-1:0]   btr_q, btr_d;
  logic [i2cs_pkg::COUNT_W-1:0]   rpos_inc;

  // Hold state between steps
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= i2cs_pkg::PH_IDLE;
      wpos_q  <= '0;
      rpos_q  <= '0;
      addr_q  <= '0;
      btw_q   <= '0;
      btr_q   <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      wpos_q  <= wpos_d;
      rpos_q  <= rpos_d;
      addr_q  <= addr_d;
      btw_q   <= btw_d;
      btr_q   <= btr_d;
    end
  end

  assign rd_addr_o = wpos_q;
  assign rpos_inc  = rpos_q + 1'b1;

  // Route loads to the write buffer
  always_comb begin
    wr_o.en   = step_i && (item_i.mode == i2cs_pkg::MODE_LOAD);
    wr_o.idx  = item_i.load_index;
    wr_o.data = item_i.load_byte;
  end

  // Next state and result
  always_comb begin
    phase_d = phase_q;
    wpos_d  = wpos_q;
    rpos_d  = rpos_q;
    addr_d  = addr_q;
    btw_d   = btw_q;
    btr_d   = btr_q;

    rsp_o             = '0;
    rsp_o.bus_command = i2cs_pkg::CMD_NONE;

    unique case (item_i.mode)
      i2cs_pkg::MODE_LOAD: begin
        // store handled by the buffer port
      end
      i2cs_pkg::MODE_BEGIN: begin
        if (phase_q == i2cs_pkg::PH_IDLE || phase_q == i2cs_pkg::PH_ERROR) begin
          addr_d  = item_i.slave_address;
          btw_d   = (item_i.write_count > WriteCap) ? WriteCap : item_i.write_count;
          btr_d   = (item_i.read_count > i2cs_pkg::READ_LIMIT) ?
                    i2cs_pkg::READ_LIMIT : item_i.read_count;
          phase_d = i2cs_pkg::PH_START;
          rsp_o.bus_command = i2cs_pkg::CMD_START;
        end
      end
      i2cs_pkg::MODE_DONE: begin
        unique case (phase_q)
          i2cs_pkg::PH_START: begin
            wpos_d = '0;
            rpos_d = '0;
            rsp_o.bus_command = i2cs_pkg::CMD_TX;
            // Write-first or probe sends the write address
            if (btw_q != '0 || btr_q == '0) begin
              phase_d       = i2cs_pkg::PH_WRITE;
              rsp_o.tx_byte = {addr_q, 1'b0};
            end else begin
              phase_d       = i2cs_pkg::PH_ACK;
              rsp_o.tx_byte = {addr_q, 1'b1};
            end
          end
          i2cs_pkg::PH_WRITE: begin
            if (item_i.ack_missing) begin
              phase_d = i2cs_pkg::PH_ERROR;
            end else if (wpos_q < btw_q) begin
              rsp_o.bus_command = i2cs_pkg::CMD_TX;
              rsp_o.tx_byte     = rd_data_i;
              wpos_d            = wpos_q + 1'b1;
            end else if (btr_q != '0) begin
              phase_d           = i2cs_pkg::PH_RESTART;
              rsp_o.bus_command = i2cs_pkg::CMD_RESTART;
            end else begin
              phase_d           = i2cs_pkg::PH_STOP;
              rsp_o.bus_command = i2cs_pkg::CMD_STOP;
            end
          end
          i2cs_pkg::PH_RESTART: begin
            phase_d           = i2cs_pkg::PH_ACK;
            rsp_o.bus_command = i2cs_pkg::CMD_TX;
            rsp_o.tx_byte     = {addr_q, 1'b1};
          end
          i2cs_pkg::PH_ACK: begin
            phase_d           = i2cs_pkg::PH_READ;
            rsp_o.bus_command = i2cs_pkg::CMD_RX;
          end
          i2cs_pkg::PH_READ: begin
            rsp_o.rx_valid = 1'b1;
            rsp_o.rx_byte  = item_i.received_byte;
            rsp_o.rx_index = rpos_q[i2cs_pkg::RIDX_W-1:0];
            rpos_d         = rpos_inc;
            // NACK the last byte, ACK the others
            if (rpos_inc >= btr_q) begin
              phase_d           = i2cs_pkg::PH_NACK;
              rsp_o.bus_command = i2cs_pkg::CMD_NACK;
            end else begin
              phase_d           = i2cs_pkg::PH_ACK;
              rsp_o.bus_command = i2cs_pkg::CMD_ACK;
            end
          end
          i2cs_pkg::PH_NACK: begin
            phase_d           = i2cs_pkg::PH_STOP;
            rsp_o.bus_command = i2cs_pkg::CMD_STOP;
          end
          i2cs_pkg::PH_STOP: begin
            phase_d = i2cs_pkg::PH_IDLE;
          end
          default: begin
            // completion while idle or in error
            phase_d = i2cs_pkg::PH_ERROR;
          end
        endcase
      end
      default: begin
        // unused mode: no effect
      end
    endcase

    // Status after the step
    unique case (phase_d)
      i2cs_pkg::PH_IDLE:  rsp_o.status = i2cs_pkg::STATUS_IDLE;
      i2cs_pkg::PH_ERROR: rsp_o.status = i2cs_pkg::STATUS_ERROR;
      default:            rsp_o.status = i2cs_pkg::STATUS_BUSY;
    endcase
  end

endmodule

// ===== rtl/core/i2c_master_write_read_sequencer.sv =====
// ----------------------------------------------------------------------------
// i2c_master_write_read_sequencer
// Top level: input register, transaction state machine, result register.
// ----------------------------------------------------------------------------
// Every request (load a byte, begin a transaction, or report a finished bus
// operation) yields exactly one result carrying the next bus command, any
// byte to transmit, any received byte with its index, and the status after
// the request. One request is taken per clock cycle while the result channel
// is not stalled; a request goes into an input register, the state machine
// handles it from there, and its result is held in the result register.
// The single state update per request in the state machine sets this rate.
// The write buffer is a register file of min(BufferDepth, 16) bytes read at
// the current write position.
module i2c_master_write_read_sequencer #(
  parameter int BufferDepth = i2cs_pkg::BUFFER_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  i2cs_req_if.sink          req_i,
  i2cs_rsp_if.source        rsp_o
);

  logic                          in_valid_q;
  i2cs_pkg::item_t               in_q;
  logic                          out_valid_q;
  i2cs_pkg::rsp_t                out_q;
  logic                          advance;
  logic                          accept;
  i2cs_pkg::item_t               req_item;
  i2cs_pkg::rsp_t                fsm_rsp;
  i2cs_pkg::wbuf_wr_t            wbuf_wr;
  logic [i2cs_pkg::COUNT_W-1:0]  wbuf_addr;
  logic [i2cs_pkg::BYTE_W-1:0]   wbuf_data;

  // Gather the request payload
  always_comb begin
    req_item.mode          = req_i.mode;
    req_item.slave_address = req_i.slave_address;
    req_item.write_count   = req_i.write_count;
    req_item.read_count    = req_i.read_count;
    req_item.load_index    = req_i.load_index;
    req_item.load_byte     = req_i.load_byte;
    req_item.ack_missing   = req_i.ack_missing;
    req_item.received_byte = req_i.received_byte;
  end

  // Advance when the result register is free or being drained
  assign advance     = in_valid_q && (!out_valid_q || rsp_o.ready);
  assign req_i.ready = !in_valid_q || advance;
  assign accept      = req_i.valid && req_i.ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (accept) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= req_item;
    end
  end

  i2cs_wbuf #(
    .BufferDepth (BufferDepth)
  ) u_wbuf (
    .clk_i     (clk_i),
    .wr_i      (wbuf_wr),
    .rd_addr_i (wbuf_addr),
    .rd_data_o (wbuf_data)
  );

  i2cs_fsm #(
    .BufferDepth (BufferDepth)
  ) u_fsm (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (advance),
    .item_i    (in_q),
    .rd_data_i (wbuf_data),
    .rd_addr_o (wbuf_addr),
    .wr_o      (wbuf_wr),
    .rsp_o     (fsm_rsp)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_q <= fsm_rsp;
    end
  end

  // Drive the result channel
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.bus_command = out_q.bus_command;
  assign rsp_o.tx_byte     = out_q.tx_byte;
  assign rsp_o.rx_valid    = out_q.rx_valid;
  assign rsp_o.rx_byte     = out_q.rx_byte;
  assign rsp_o.rx_index    = out_q.rx_index;
  assign rsp_o.status      = out_q.status;

endmodule

// ===== rtl/core/i2cs_checker.sv =====
// ----------------------------------------------------------------------------
// i2cs_checker
// Port-level checks of the I2C sequencer result channel, bound to the top.
// ----------------------------------------------------------------------------
module i2cs_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          rsp_valid_i,
  input logic                          rsp_ready_i,
  input logic [i2cs_pkg::CMD_W-1:0]    bus_command_i,
  input logic [i2cs_pkg::BYTE_W-1:0]   tx_byte_i,
  input logic                          rx_valid_i,
  input logic [i2cs_pkg::STAT_W-1:0]   status_i
);

  // Hold a stalled result
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=>
      rsp_valid_i && $stable(bus_command_i) && $stable(tx_byte_i) && $stable(status_i))
    else $error("stalled result changed");

  // A received byte comes with its ACK or NACK
  a_rx_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rx_valid_i |->
      bus_command_i == i2cs_pkg::CMD_ACK || bus_command_i == i2cs_pkg::CMD_NACK)
    else $error("received byte without ack or nack");

  // Transmit data only with a transmit command
  a_tx_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && bus_command_i != i2cs_pkg::CMD_TX |-> tx_byte_i == '0)
    else $error("tx byte set without transmit");

  // Error reports issue no bus command, a start command reports busy
  a_err_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && status_i == i2cs_pkg::STATUS_ERROR |->
      bus_command_i == i2cs_pkg::CMD_NONE)
    else $error("command issued with error status");

  a_start_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && bus_command_i == i2cs_pkg::CMD_START |->
      status_i == i2cs_pkg::STATUS_BUSY)
    else $error("start without busy status");

endmodule

bind i2c_master_write_read_sequencer i2cs_checker u_i2cs_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .bus_command_i (rsp_o.bus_command),
  .tx_byte_i     (rsp_o.tx_byte),
  .rx_valid_i    (rsp_o.rx_valid),
  .status_i      (rsp_o.status)
);
